>>> hw/rtl/ssdw_pkg.sv
// shared types and constants for the sensor status debounce window block
package ssdw_pkg;

    localparam int STATUS_W  = 3;
    localparam int WINDOW_W  = 2;
    localparam int COUNT_W   = 4;
    localparam int VALUE_W   = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [WINDOW_W-1:0] window_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    localparam window_t WIN_UNSPEC  = 2'd0;
    localparam window_t WIN_INVALID = 2'd1;
    localparam window_t WIN_WITHIN  = 2'd2;
    localparam window_t WIN_OUTSIDE = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_LIMIT  = 2'd0,
        CFG_UPPER_LIMIT  = 2'd1,
        CFG_LIMIT_ENABLE = 2'd2,
        CFG_IGNORE_AUTO  = 2'd3
    } cfg_index_t;

    // result of one debouncer step
    typedef struct packed {
        status_t confirmed;
        logic    changed;
    } deb_result_t;

endpackage

>>> hw/rtl/ssdw_window.sv
// window comparator: classifies a reading against the user limits, or flags it invalid
module ssdw_window
(
    input  ssdw_pkg::value_t  reading,
    input  logic              reading_invalid,
    input  ssdw_pkg::value_t  lower_limit,
    input  ssdw_pkg::value_t  upper_limit,
    output ssdw_pkg::window_t window_status
);

    always_comb
    begin
        if (reading_invalid)
        begin
            window_status = ssdw_pkg::WIN_INVALID;
        end
        else if ((reading > upper_limit) || (reading < lower_limit))
        begin
            window_status = ssdw_pkg::WIN_OUTSIDE;
        end
        else
        begin
            window_status = ssdw_pkg::WIN_WITHIN;
        end
    end

endmodule

>>> hw/rtl/ssdw_debounce.sv
// status debouncer: candidate tracking, saturating count and confirmation
module ssdw_debounce
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  ssdw_pkg::status_t     status,
    input  ssdw_pkg::count_t      confirm_count,
    output ssdw_pkg::deb_result_t result
);

    ssdw_pkg::status_t confirmed_reg;
    ssdw_pkg::status_t confirmed_next;
    ssdw_pkg::status_t candidate_reg;
    ssdw_pkg::status_t candidate_next;
    ssdw_pkg::count_t  count_reg;
    ssdw_pkg::count_t  count_next;
    ssdw_pkg::count_t  count_inc;
    logic              changed;

    assign count_inc = (count_reg < ssdw_pkg::COUNT_MAX) ?
                       ssdw_pkg::count_t'(count_reg + 1'b1) : count_reg;

    always_comb
    begin
        confirmed_next = confirmed_reg;
        candidate_next = candidate_reg;
        count_next     = count_reg;
        changed        = 1'b0;
        if (step && (status != confirmed_reg))
        begin
            if (status != candidate_reg)
            begin
                candidate_next = status;
                count_next     = '0;
            end
            else
            begin
                count_next = count_inc;
                if (count_inc >= confirm_count)
                begin
                    confirmed_next = status;
                    changed        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirmed_reg <= '0;
            candidate_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            confirmed_reg <= confirmed_next;
            candidate_reg <= candidate_next;
            count_reg     <= count_next;
        end
    end

    assign result.confirmed = confirmed_next;
    assign result.changed   = changed;

endmodule

>>> hw/rtl/sensor_status_debounce_window.sv
// top level of the sensor status debounce window block
//
// one sensor reading enters per item on the s_axis channel; one result
// item per reading leaves on the m_axis channel, in order
// configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while idle, which the block does not enforce; index
// 0 lower limit, 1 upper limit, 2 user limit enable, 3 ignore auto status
// an accepted item is held in the input register, then classified and run
// through both debouncers combinationally as it moves to the result register
// a result item is valid on m_axis once it is held in the result register
// throughput: one item per cycle while m_axis_tready is high; the debouncer
// state update on the move from input to result register sets that figure
// when the receiver stalls, the result register holds its item and the
// input register still takes one more item; after that s_axis_tready drops
// until the result is taken
// reset clears both valid flags, the debouncer state, the latched value and
// the configuration to its defaults (full window, both enables off)
module sensor_status_debounce_window
#(
    parameter int CONFIRM_COUNT = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] reported_status, [66:3] reading, [67] reading_invalid, [71:68] unused
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] confirmed_reported, [4:3] confirmed_window, [5] reported_changed,
    // [6] window_changed, [70:7] latched_value, [71] zero
    output logic [71:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam ssdw_pkg::count_t CONFIRM_THR = ssdw_pkg::count_t'(CONFIRM_COUNT);

    ssdw_pkg::value_t  lower_limit_reg;
    ssdw_pkg::value_t  upper_limit_reg;
    logic              limit_enable_reg;
    logic              ignore_auto_reg;

    logic              in_valid_reg;
    ssdw_pkg::status_t in_status_reg;
    ssdw_pkg::value_t  in_reading_reg;
    logic              in_invalid_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [71:0]       out_data_reg;
    logic [71:0]       out_data_next;

    ssdw_pkg::value_t  latch_reg;
    ssdw_pkg::value_t  latch_next;

    logic              move;
    logic              step_rep;
    logic              step_win;
    ssdw_pkg::window_t window_status;
    ssdw_pkg::deb_result_t rep_result;
    ssdw_pkg::deb_result_t win_result;

    assign move          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || move;
    assign step_rep      = move && !ignore_auto_reg;
    assign step_win      = move && limit_enable_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_limit_reg  <= {1'b1, {(ssdw_pkg::VALUE_W-1){1'b0}}};
            upper_limit_reg  <= {1'b0, {(ssdw_pkg::VALUE_W-1){1'b1}}};
            limit_enable_reg <= 1'b0;
            ignore_auto_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (ssdw_pkg::cfg_index_t'(cfg_index))
                ssdw_pkg::CFG_LOWER_LIMIT:  lower_limit_reg  <= cfg_data;
                ssdw_pkg::CFG_UPPER_LIMIT:  upper_limit_reg  <= cfg_data;
                ssdw_pkg::CFG_LIMIT_ENABLE: limit_enable_reg <= cfg_data[0];
                ssdw_pkg::CFG_IGNORE_AUTO:  ignore_auto_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_status_reg  <= s_axis_tdata[2:0];
            in_reading_reg <= s_axis_tdata[66:3];
            in_invalid_reg <= s_axis_tdata[67];
        end
    end

    ssdw_window u_window
    (
        .reading         (in_reading_reg),
        .reading_invalid (in_invalid_reg),
        .lower_limit     (lower_limit_reg),
        .upper_limit     (upper_limit_reg),
        .window_status   (window_status)
    );

    ssdw_debounce u_deb_reported
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step_rep),
        .status        (in_status_reg),
        .confirm_count (CONFIRM_THR),
        .result        (rep_result)
    );

    ssdw_debounce u_deb_window
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step_win),
        .status        ({1'b0, window_status}),
        .confirm_count (CONFIRM_THR),
        .result        (win_result)
    );

    always_comb
    begin
        latch_next = latch_reg;
        if (rep_result.changed || win_result.changed)
        begin
            latch_next = in_reading_reg;
        end
    end

    assign out_data_next = {1'b0, latch_next, win_result.changed, rep_result.changed,
                            win_result.confirmed[ssdw_pkg::WINDOW_W-1:0],
                            rep_result.confirmed};
    assign out_valid_next = move || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            latch_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            latch_reg     <= latch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
